// ===== sv/kcg_pkg.sv =====
// shared constants and types of the k-combination generator
`timescale 1ns / 1ps

package kcg_pkg;

  localparam int MAX_K_DEF      = 16;
  localparam int VALUE_BITS_DEF = 8;

  localparam int SET_SIZE_W     = 8;
  localparam int CHOOSE_COUNT_W = 5;
  localparam int POSITION_W     = 4;
  localparam int ELEM_VALUE_W   = 8;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 8;
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 16;

  localparam logic [SET_SIZE_W-1:0]     SET_SIZE_RST     = 8'd7;
  localparam logic [CHOOSE_COUNT_W-1:0] CHOOSE_COUNT_RST = 5'd5;

  // one result from the sequencer to the output register
  typedef struct packed {
    logic                    valid;
    logic [POSITION_W-1:0]   position;
    logic [ELEM_VALUE_W-1:0] element_value;
    logic                    last_of_run;
    logic                    done_res;
  } emit_t;

endpackage

// ===== sv/kcg_seq.sv =====
// sequencer, element store and shared add/compare unit of the k-combination generator
`timescale 1ns / 1ps

module kcg_seq #(
  parameter int MAX_K      = kcg_pkg::MAX_K_DEF,
  parameter int VALUE_BITS = kcg_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                restart,
  input  logic [kcg_pkg::SET_SIZE_W-1:0]      set_size,
  input  logic [kcg_pkg::CHOOSE_COUNT_W-1:0]  choose_count,
  input  logic                                slot_free,
  output logic                                idle,
  output kcg_pkg::emit_t                      em
);

  import kcg_pkg::*;

  localparam int IDXW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW   = ((IDXW > CHOOSE_COUNT_W) ? IDXW : CHOOSE_COUNT_W) + 1;
  localparam int DW   = CHOOSE_COUNT_W;
  localparam int LW   = ((VALUE_BITS > SET_SIZE_W) ? VALUE_BITS : SET_SIZE_W) + DW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_EMIT,
    ST_DONE
  } state_t;

  state_t                state_r;
  logic                  started_r;
  logic                  exhausted_r;
  logic [IDXW-1:0]       idx_r;
  logic [DW-1:0]         dist_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] elem_r [MAX_K];

  logic [VALUE_BITS-1:0] elem_rd;
  logic [CW-1:0]         k_ext;
  logic [CW-1:0]         last_idx;
  logic                  at_last;
  logic                  k_bad;
  logic [LW-1:0]         lhs;
  logic                  below;

  assign elem_rd  = elem_r[idx_r];
  assign k_ext    = CW'(choose_count);
  assign last_idx = k_ext - CW'(1);
  assign at_last  = (CW'(idx_r) == last_idx);
  assign k_bad    = (choose_count == '0) || (k_ext > CW'(MAX_K)) ||
                    (LW'(choose_count) > LW'(set_size));
  // element plus its distance from the top position, against n
  assign lhs      = LW'(elem_rd) + LW'(dist_r);
  assign below    = lhs < LW'(set_size);

  assign idle = (state_r == ST_IDLE);

  always_comb begin
    em = '0;
    unique case (state_r)
      ST_EMIT: begin
        em.valid         = slot_free;
        em.position      = POSITION_W'(idx_r);
        em.element_value = ELEM_VALUE_W'(elem_rd);
        em.last_of_run   = at_last;
        em.done_res      = 1'b0;
      end
      ST_DONE: begin
        em.valid         = slot_free;
        em.last_of_run   = 1'b1;
        em.done_res      = 1'b1;
      end
      default: begin
        em = '0;
      end
    endcase
  end

  // element store, no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_FILL) begin
      elem_r[idx_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      exhausted_r <= 1'b0;
      idx_r       <= '0;
      dist_r      <= '0;
      val_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            if (restart || !started_r) begin
              started_r <= 1'b1;
              if (k_bad) begin
                exhausted_r <= 1'b1;
                state_r     <= ST_DONE;
              end else begin
                exhausted_r <= 1'b0;
                idx_r       <= '0;
                val_r       <= VALUE_BITS'(1);
                state_r     <= ST_FILL;
              end
            end else if (exhausted_r || k_bad) begin
              exhausted_r <= 1'b1;
              state_r     <= ST_DONE;
            end else begin
              idx_r   <= IDXW'(last_idx);
              dist_r  <= '0;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (below) begin
            val_r   <= VALUE_BITS'(elem_rd + 1'b1);
            state_r <= ST_FILL;
          end else if (idx_r == '0) begin
            exhausted_r <= 1'b1;
            state_r     <= ST_DONE;
          end else begin
            idx_r  <= idx_r - 1'b1;
            dist_r <= dist_r + 1'b1;
          end
        end
        ST_FILL: begin
          val_r <= VALUE_BITS'(val_r + 1'b1);
          if (at_last) begin
            idx_r   <= '0;
            state_r <= ST_EMIT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (at_last) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/k_combination_generator.sv =====
// top level of the k-combination generator: config registers, sequencer and output register
`timescale 1ns / 1ps

// Each request on the input stream returns the next k-element subset of 1..n in
// lexicographic order as k results (position 0 first, tlast on the final one);
// restart set goes back to 1..k. Once all subsets are out, or if k is zero, above
// MAX_K or above n, a request gives one result with tuser (done) set. Work runs on a
// single element read port and one add/compare unit: a step request scans down from the
// last position to the increment point and refills from there, a restart fills all k
// elements, and then the results go out. in_tready is low from a request until its last
// result has entered the output register. The user writes configuration only while the
// block is idle; the block itself does not enforce this.

module k_combination_generator #(
  parameter int MAX_K      = kcg_pkg::MAX_K_DEF,
  parameter int VALUE_BITS = kcg_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [kcg_pkg::IN_TDATA_W-1:0]    in_tdata,   // restart
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [kcg_pkg::OUT_TDATA_W-1:0]   out_tdata,  // position, element_value
  output logic                              out_tlast,
  output logic                              out_tuser,  // done_res
  input  logic                              cfg_we,
  input  logic [kcg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [kcg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import kcg_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SET_SIZE     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHOOSE_COUNT = 1'd1;

  logic [SET_SIZE_W-1:0]     set_size_r;
  logic [CHOOSE_COUNT_W-1:0] choose_count_r;
  logic                      out_valid_r;
  logic [POSITION_W-1:0]     position_r;
  logic [ELEM_VALUE_W-1:0]   element_value_r;
  logic                      last_r;
  logic                      done_r;

  logic  idle;
  logic  start;
  logic  slot_free;
  emit_t em;

  assign in_tready = idle;
  assign start     = in_tvalid && idle;
  assign slot_free = !out_valid_r || out_tready;

  kcg_seq #(
    .MAX_K      (MAX_K),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .restart      (in_tdata[0]),
    .set_size     (set_size_r),
    .choose_count (choose_count_r),
    .slot_free    (slot_free),
    .idle         (idle),
    .em           (em)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r     <= SET_SIZE_RST;
      choose_count_r <= CHOOSE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_SIZE:     set_size_r     <= cfg_wdata[SET_SIZE_W-1:0];
        REG_CHOOSE_COUNT: choose_count_r <= cfg_wdata[CHOOSE_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (em.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em.valid) begin
      position_r      <= em.position;
      element_value_r <= em.element_value;
      last_r          <= em.last_of_run;
      done_r          <= em.done_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - POSITION_W - ELEM_VALUE_W)'(0), element_value_r, position_r};
  assign out_tlast  = last_r;
  assign out_tuser  = done_r;

endmodule

// ===== sv/kcg_checker.sv =====
// port checker of the k-combination generator and its bind
`timescale 1ns / 1ps

module kcg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [kcg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              out_tlast,
  input logic                              out_tuser
);

  import kcg_pkg::*;

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("stalled result changed");

  // done result is an element-free closing result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("malformed done result");

  // a request keeps the input closed for the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted back to back");

  // no new request while a run is only partly out
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open mid run");

endmodule

bind k_combination_generator kcg_checker u_kcg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
